// File: hdl/tlbpt_pkg.sv
`timescale 1ns / 1ps

package tlbpt_pkg;

   // address split
   localparam int ADDR_W      = 16;
   localparam int OFFSET_BITS = 8;
   localparam int PAGE_W      = ADDR_W - OFFSET_BITS;

   // tlb and page table sizes (page count is a power of two)
   localparam int TLB_ENTRIES = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int SLOT_W      = $clog2(TLB_ENTRIES);
   localparam int IDX_W       = $clog2(PAGE_COUNT);

   // stored tag and frame are one byte each
   localparam int TAG_W   = 8;
   localparam int FRAME_W = 8;

   // counters
   localparam int HIT_W  = 16;
   localparam int FCNT_W = 9;
   localparam logic [HIT_W-1:0]  HIT_MAX  = {HIT_W{1'b1}};
   localparam logic [FCNT_W-1:0] FCNT_MAX = {FCNT_W{1'b1}};

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TLB_ENTRIES - 1);

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_RESOLVE
   } tlbpt_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic emit;
      logic hit_update;
      logic fill_tlb;
      logic alloc_frame;
   } tlbpt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tlb_hit;
      logic page_present;
   } tlbpt_status_type;

endpackage

// File: hdl/tlbpt_ctrl.sv
`timescale 1ns / 1ps

module tlbpt_ctrl import tlbpt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tlbpt_status_type status,
   output logic             busy,
   output tlbpt_cmd_type    cmd
);

   tlbpt_state_type state_ff;
   tlbpt_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_RESOLVE: begin
            busy            = 1'b1;
            cmd.emit        = 1'b1;
            cmd.hit_update  = status.tlb_hit;
            cmd.fill_tlb    = !status.tlb_hit;
            cmd.alloc_frame = !status.tlb_hit && !status.page_present;
         end
         default: begin
            cmd  = '0;
            busy = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/tlbpt_datapath.sv
`timescale 1ns / 1ps

module tlbpt_datapath import tlbpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  tlbpt_cmd_type      cmd,
   output tlbpt_status_type   status,
   input  logic [ADDR_W-1:0]  req_virtual_address,
   output logic               rsp_strobe,
   output logic [15:0]        rsp_physical_address,
   output logic [7:0]         rsp_page_number,
   output logic [7:0]         rsp_page_offset,
   output logic               rsp_tlb_hit,
   output logic               rsp_page_fault,
   output logic [HIT_W-1:0]   rsp_hits_so_far,
   output logic [FCNT_W-1:0]  rsp_faults_so_far
);

   // tlb storage
   logic [TAG_W-1:0]       tlb_tag_ff   [TLB_ENTRIES];
   logic [FRAME_W-1:0]     tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [SLOT_W-1:0]      fill_slot_ff;
   logic [SLOT_W-1:0]      fill_slot_in;

   // page table
   logic [FRAME_W-1:0]    page_frame_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] page_present_ff;

   // running counts
   logic [HIT_W-1:0]  hit_total_ff;
   logic [HIT_W-1:0]  hit_total_in;
   logic [FCNT_W-1:0] next_free_ff;
   logic [FCNT_W-1:0] next_free_in;

   // captured lookup
   logic [ADDR_W-1:0]  va_ff;
   logic               hit_ff;
   logic               present_ff;
   logic [FRAME_W-1:0] hit_frame_ff;
   logic [FRAME_W-1:0] rd_frame_ff;

   // request split
   logic [PAGE_W-1:0]  req_page;
   logic [TAG_W-1:0]   req_tag;
   logic [IDX_W-1:0]   req_idx;
   logic               lookup_hit;
   logic [FRAME_W-1:0] lookup_frame;

   // resolve side
   logic [PAGE_W-1:0]      cur_page;
   logic [OFFSET_BITS-1:0] cur_offset;
   logic [IDX_W-1:0]       cur_idx;
   logic [TAG_W-1:0]       cur_tag;
   logic [FRAME_W-1:0]     frame_sel;
   logic [15:0]            paddr;

   assign req_page = req_virtual_address[ADDR_W-1:OFFSET_BITS];
   assign req_tag  = TAG_W'(req_page);
   assign req_idx  = IDX_W'(req_page);

   // parallel tag compare, last match wins
   always_comb begin
      lookup_hit   = 1'b0;
      lookup_frame = '0;
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         if (tlb_valid_ff[k] && (tlb_tag_ff[k] == req_tag)) begin
            lookup_hit   = 1'b1;
            lookup_frame = tlb_frame_ff[k];
         end
      end
   end

   // capture address and lookup results
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff     <= 1'b0;
         present_ff <= 1'b0;
      end else if (cmd.capture) begin
         hit_ff     <= lookup_hit;
         present_ff <= page_present_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         va_ff        <= req_virtual_address;
         hit_frame_ff <= lookup_frame;
      end
   end

   assign status.tlb_hit      = hit_ff;
   assign status.page_present = present_ff;

   assign cur_page   = va_ff[ADDR_W-1:OFFSET_BITS];
   assign cur_offset = va_ff[OFFSET_BITS-1:0];
   assign cur_idx    = IDX_W'(cur_page);
   assign cur_tag    = TAG_W'(cur_page);

   // page frame memory, registered read at capture, write on fault
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_frame_ff <= page_frame_mem[req_idx];
      end
      if (cmd.alloc_frame) begin
         page_frame_mem[cur_idx] <= frame_sel;
      end
   end

   // frame choice: tlb, page table, or newly allocated
   always_comb begin
      if (hit_ff) begin
         frame_sel = hit_frame_ff;
      end else if (present_ff) begin
         frame_sel = rd_frame_ff;
      end else begin
         frame_sel = next_free_ff[FRAME_W-1:0];
      end
   end

   assign paddr = 16'((32'(frame_sel) << OFFSET_BITS) | 32'(cur_offset));

   // counter next values
   always_comb begin
      hit_total_in = hit_total_ff;
      if (cmd.hit_update && (hit_total_ff != HIT_MAX)) begin
         hit_total_in = hit_total_ff + 1'b1;
      end
      next_free_in = next_free_ff;
      if (cmd.alloc_frame && (next_free_ff != FCNT_MAX)) begin
         next_free_in = next_free_ff + 1'b1;
      end
      fill_slot_in = fill_slot_ff;
      if (cmd.fill_tlb) begin
         fill_slot_in = (fill_slot_ff == SLOT_LAST) ? '0 : fill_slot_ff + 1'b1;
      end
   end

   // control state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff    <= '0;
         next_free_ff    <= '0;
         fill_slot_ff    <= '0;
         tlb_valid_ff    <= '0;
         page_present_ff <= '0;
         rsp_strobe      <= 1'b0;
      end else begin
         hit_total_ff <= hit_total_in;
         next_free_ff <= next_free_in;
         fill_slot_ff <= fill_slot_in;
         rsp_strobe   <= cmd.emit;
         if (cmd.fill_tlb) begin
            tlb_valid_ff[fill_slot_ff] <= 1'b1;
         end
         if (cmd.alloc_frame) begin
            page_present_ff[cur_idx] <= 1'b1;
         end
      end
   end

   // tlb refill in fifo order
   always_ff @(posedge clock) begin
      if (cmd.fill_tlb) begin
         tlb_tag_ff[fill_slot_ff]   <= cur_tag;
         tlb_frame_ff[fill_slot_ff] <= frame_sel;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_physical_address <= paddr;
         rsp_page_number      <= 8'(cur_page);
         rsp_page_offset      <= 8'(cur_offset);
         rsp_tlb_hit          <= hit_ff;
         rsp_page_fault       <= cmd.alloc_frame;
         rsp_hits_so_far      <= hit_total_in;
         rsp_faults_so_far    <= next_free_in;
      end
   end

endmodule

// File: hdl/tlb_page_table_translator_unit.sv
`timescale 1ns / 1ps
// rsp_strobe is registered from the resolve state that follows the start transfer
// a new start is taken in the cycle the result shows; start is ignored while busy in resolve
// the steps are the registered page-table read at capture and the resolve/write-back step
// receiver cannot stall; rsp_strobe is high for one cycle, other rsp_ ports are held
// reset (synchronous): clears tlb valid bits, page-present bits, fifo slot and counters at once

module tlb_page_table_translator_unit import tlbpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ADDR_W-1:0]  req_virtual_address,
   output logic               rsp_strobe,
   output logic [15:0]        rsp_physical_address,
   output logic [7:0]         rsp_page_number,
   output logic [7:0]         rsp_page_offset,
   output logic               rsp_tlb_hit,
   output logic               rsp_page_fault,
   output logic [HIT_W-1:0]   rsp_hits_so_far,
   output logic [FCNT_W-1:0]  rsp_faults_so_far
);

   tlbpt_cmd_type    cmd;
   tlbpt_status_type status;

   // sequencer
   tlbpt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // tlb, page table and counters
   tlbpt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_virtual_address  (req_virtual_address),
      .rsp_strobe           (rsp_strobe),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_number      (rsp_page_number),
      .rsp_page_offset      (rsp_page_offset),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_hits_so_far      (rsp_hits_so_far),
      .rsp_faults_so_far    (rsp_faults_so_far)
   );

   // a transfer in enters the resolve state
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not enter resolve");

   // resolve always returns to idle in the next cycle
   a_busy_once: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("resolve held longer than one cycle");

   // each result follows a resolve cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a resolve cycle");

   // a fault is never a tlb hit and its reported fault count is nonzero
   a_fault_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_page_fault) |-> (!rsp_tlb_hit && (rsp_faults_so_far != '0)))
      else $error("page fault reported with tlb hit or zero count");

endmodule
